>>> src/gkb_pkg.sv
`default_nettype none
package gkb_pkg;

	localparam int BEN_W     = 16;
	localparam int WGT_W     = 16;
	localparam int RAT_W     = 16;
	localparam int CAP_W     = 22;
	localparam int TOT_W     = 21;
	localparam int OIDX_W    = 6;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic [BEN_W-1:0] benefit;
		logic [WGT_W-1:0] weight;
		logic [RAT_W-1:0] ratio;
	} entry_t;

endpackage
`default_nettype wire

>>> src/gkb_div.sv
`default_nettype none
module gkb_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire  [gkb_pkg::BEN_W-1:0]     dividend,
	input  wire  [gkb_pkg::WGT_W-1:0]     divisor,
	output logic                          done,
	output logic [gkb_pkg::RAT_W-1:0]     quotient
);
	import gkb_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RAT_W-1:0]  quo_q;
	logic [WGT_W-1:0]  rem_q;
	logic [WGT_W-1:0]  dvs_q;
	logic [WGT_W:0]    rem_shift;
	logic              ge;

	assign rem_shift = {rem_q, quo_q[RAT_W-1]};
	assign ge        = rem_shift >= {1'b0, dvs_q};
	assign done      = done_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= ge ? WGT_W'(rem_shift - {1'b0, dvs_q}) : rem_shift[WGT_W-1:0];
				quo_q  <= {quo_q[RAT_W-2:0], ge};
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/gkb_mem.sv
`default_nettype none
module gkb_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire                   clk,
	input  wire                   we,
	input  wire  [AW-1:0]         waddr,
	input  wire gkb_pkg::entry_t  wdata,
	input  wire                   re,
	input  wire  [AW-1:0]         raddr,
	output gkb_pkg::entry_t       rdata
);
	import gkb_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/greedy_knapsack_best_of_two.sv
// Load: one item at a time (accept, 16 quotient steps of the ratio divider, write).
// Selection: each greedy scan reads the item memory once per stored item; a pass takes
// up to N + 1 scans; two passes plus a summing scan follow the last item if cap > 0.
// Results: one per cycle while the sink is ready; the next set loads behind the last one.
// Reset: arst_n clears capacity, item count, marks and all control; memory stays as is.
`default_nettype none
module greedy_knapsack_best_of_two #(
	parameter int MAX_ITEMS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [gkb_pkg::CAP_W-1:0]        cfg_data,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [gkb_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // benefit[15:0], weight[31:16]
	input  wire                              s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// item_index[5:0], selected[6], total_benefit[27:7], total_weight[48:28], zero pad
	output logic [gkb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser   // empty_result
);
	import gkb_pkg::*;

	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W = BEN_W + CNT_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV,
		ST_START,
		ST_SCAN,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 last_q;
	logic [BEN_W-1:0]     ben_q;
	logic [WGT_W-1:0]     wgt_q;
	logic [CNT_W-1:0]     addr_q;
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 pass_q;
	logic [CAP_W-1:0]     rw_q;
	logic                 found_q;
	logic [RAT_W-1:0]     best_q;
	logic [IDX_W-1:0]     pick_q;
	logic [WGT_W-1:0]     pick_w_q;
	logic [MAX_ITEMS-1:0] mark_b_q;
	logic [MAX_ITEMS-1:0] mark_r_q;
	logic [SUM_W-1:0]     sb1_q;
	logic [SUM_W-1:0]     sw1_q;
	logic [SUM_W-1:0]     sb2_q;
	logic [SUM_W-1:0]     sw2_q;
	logic                 win_r_q;
	logic                 empty_q;
	logic [TOT_W-1:0]     tot_b_q;
	logic [TOT_W-1:0]     tot_w_q;
	logic [CNT_W-1:0]     oidx_q;
	logic                 m_valid_q;
	logic [OIDX_W-1:0]    m_idx_q;
	logic                 m_sel_q;
	logic [TOT_W-1:0]     m_tb_q;
	logic [TOT_W-1:0]     m_tw_q;
	logic                 m_last_q;
	logic                 m_empty_q;

	logic                 in_acc;
	logic                 has_room;
	logic                 div_start;
	logic                 div_done;
	logic [RAT_W-1:0]     div_quo;
	entry_t               wr_entry;
	entry_t               rd_entry;
	logic                 rd_en;
	logic [RAT_W-1:0]     key;
	logic                 mark_cur;
	logic                 fits;
	logic                 take;
	logic                 scan_done;
	logic                 out_free;
	logic [CNT_W-1:0]     oidx_nx;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign has_room      = cnt_q < CNT_W'(MAX_ITEMS);
	assign div_start     = in_acc && has_room;

	assign wr_entry.benefit = ben_q;
	assign wr_entry.weight  = wgt_q;
	assign wr_entry.ratio   = div_quo;

	assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_SUM)) && (addr_q < cnt_q);
	assign key       = pass_q ? rd_entry.ratio : rd_entry.benefit;
	assign mark_cur  = pass_q ? mark_r_q[idx_s1] : mark_b_q[idx_s1];
	assign fits      = ({1'b0, rw_q} + (CAP_W+1)'(rd_entry.weight)) <= {1'b0, cap_q};
	assign take      = v_s1 && !mark_cur && (!found_q || key > best_q) && fits;
	assign scan_done = !v_s1 && (addr_q == cnt_q);
	assign out_free  = !m_valid_q || m_axis_tready;
	assign oidx_nx   = CNT_W'(oidx_q + 1'b1);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_tw_q, m_tb_q, m_sel_q, m_idx_q};
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_empty_q;

	gkb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_axis_tdata[BEN_W-1:0]),
		.divisor  (s_axis_tdata[BEN_W +: WGT_W]),
		.done     (div_done),
		.quotient (div_quo)
	);

	gkb_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (div_done),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cap_q     <= '0;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			ben_q     <= '0;
			wgt_q     <= '0;
			addr_q    <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			pass_q    <= 1'b0;
			rw_q      <= '0;
			found_q   <= 1'b0;
			best_q    <= '0;
			pick_q    <= '0;
			pick_w_q  <= '0;
			mark_b_q  <= '0;
			mark_r_q  <= '0;
			sb1_q     <= '0;
			sw1_q     <= '0;
			sb2_q     <= '0;
			sw2_q     <= '0;
			win_r_q   <= 1'b0;
			empty_q   <= 1'b0;
			tot_b_q   <= '0;
			tot_w_q   <= '0;
			oidx_q    <= '0;
			m_valid_q <= 1'b0;
			m_idx_q   <= '0;
			m_sel_q   <= 1'b0;
			m_tb_q    <= '0;
			m_tw_q    <= '0;
			m_last_q  <= 1'b0;
			m_empty_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (m_axis_tready && (state_q != ST_OUT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						last_q <= s_axis_tlast;
						ben_q  <= s_axis_tdata[BEN_W-1:0];
						wgt_q  <= s_axis_tdata[BEN_W +: WGT_W];
						if (has_room) begin
							state_q <= ST_DIV;
						end else if (s_axis_tlast) begin
							state_q <= ST_START;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cnt_q   <= CNT_W'(cnt_q + 1'b1);
						state_q <= last_q ? ST_START : ST_LOAD;
					end
				end
				ST_START: begin
					empty_q <= (cap_q == '0);
					oidx_q  <= '0;
					addr_q  <= '0;
					v_s1    <= 1'b0;
					found_q <= 1'b0;
					pass_q  <= 1'b0;
					rw_q    <= '0;
					tot_b_q <= '0;
					tot_w_q <= '0;
					state_q <= (cap_q == '0) ? ST_OUT : ST_SCAN;
				end
				ST_SCAN: begin
					v_s1   <= rd_en;
					idx_s1 <= addr_q[IDX_W-1:0];
					if (rd_en) begin
						addr_q <= CNT_W'(addr_q + 1'b1);
					end
					if (take) begin
						found_q  <= 1'b1;
						best_q   <= key;
						pick_q   <= idx_s1;
						pick_w_q <= rd_entry.weight;
					end
					if (scan_done) begin
						addr_q  <= '0;
						found_q <= 1'b0;
						if (found_q) begin
							if (pass_q) begin
								mark_r_q[pick_q] <= 1'b1;
							end else begin
								mark_b_q[pick_q] <= 1'b1;
							end
							rw_q <= CAP_W'(rw_q + pick_w_q);
						end else if (!pass_q) begin
							pass_q <= 1'b1;
							rw_q   <= '0;
						end else begin
							sb1_q   <= '0;
							sw1_q   <= '0;
							sb2_q   <= '0;
							sw2_q   <= '0;
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					v_s1   <= rd_en;
					idx_s1 <= addr_q[IDX_W-1:0];
					if (rd_en) begin
						addr_q <= CNT_W'(addr_q + 1'b1);
					end
					if (v_s1 && mark_b_q[idx_s1]) begin
						sb1_q <= SUM_W'(sb1_q + rd_entry.benefit);
						sw1_q <= SUM_W'(sw1_q + rd_entry.weight);
					end
					if (v_s1 && mark_r_q[idx_s1]) begin
						sb2_q <= SUM_W'(sb2_q + rd_entry.benefit);
						sw2_q <= SUM_W'(sw2_q + rd_entry.weight);
					end
					if (scan_done) begin
						win_r_q <= !(sb1_q > sb2_q);
						tot_b_q <= (sb1_q > sb2_q) ? TOT_W'(sb1_q) : TOT_W'(sb2_q);
						tot_w_q <= (sb1_q > sb2_q) ? TOT_W'(sw1_q) : TOT_W'(sw2_q);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_idx_q   <= OIDX_W'(oidx_nx);
						m_sel_q   <= !empty_q && (win_r_q ? mark_r_q[oidx_q[IDX_W-1:0]]
						                                  : mark_b_q[oidx_q[IDX_W-1:0]]);
						m_tb_q    <= tot_b_q;
						m_tw_q    <= tot_w_q;
						m_last_q  <= (oidx_nx == cnt_q);
						m_empty_q <= empty_q;
						oidx_q    <= oidx_nx;
						if (oidx_nx == cnt_q) begin
							mark_b_q <= '0;
							mark_r_q <= '0;
							cnt_q    <= '0;
							rw_q     <= '0;
							state_q  <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/gkb_checker.sv
`default_nettype none
module gkb_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_axis_tready,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [gkb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input wire                              m_axis_tlast,
	input wire                              m_axis_tuser
);
	import gkb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[48:6] == '0)
		else $error("empty result carries a selection or totals");

	a_frame_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken while results of a set remain");

	a_frame_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a result run");

endmodule

bind greedy_knapsack_best_of_two gkb_checker u_gkb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
